/* rtl/sha256_message_hasher_assert.svh */
// Assertion macros used by the hasher top level.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Clocked property check, disabled while reset is asserted.
`define SHA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be true at a clock edge.
`define SHA_ASSERT_NEVER(label, cond, msg) \
  `SHA_ASSERT(label, !(cond), msg)

`endif

/* rtl/sha_pkg.sv */
// Types, constants and helper functions for the SHA-256 hasher.
`timescale 1ns / 1ps
package sha_pkg;

  typedef logic [7:0][31:0] hash_t;

  // Schedule window taps used by one round
  typedef struct packed {
    logic [31:0] w0;
    logic [31:0] w1;
    logic [31:0] w9;
    logic [31:0] w14;
  } sched_taps_t;

  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PadMark = 8'h80;
  localparam logic [5:0] LenFieldPos = 6'd56;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/sha_round.sv */
// One SHA-256 compression round plus the next message schedule word.
`timescale 1ns / 1ps
module sha_round (
  input  sha_pkg::hash_t       vars_i,
  input  sha_pkg::sched_taps_t taps_i,
  input  logic [31:0]          k_i,
  output sha_pkg::hash_t       vars_o,
  output logic [31:0]          w_next_o
);

  logic [31:0] big_e, ch, t1, big_a, maj, t2, s0, s1;

  always_comb begin
    big_e = sha_pkg::rotr(vars_i[4], 6) ^ sha_pkg::rotr(vars_i[4], 11)
          ^ sha_pkg::rotr(vars_i[4], 25);
    ch    = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
    t1    = vars_i[7] + big_e + ch + k_i + taps_i.w0;
    big_a = sha_pkg::rotr(vars_i[0], 2) ^ sha_pkg::rotr(vars_i[0], 13)
          ^ sha_pkg::rotr(vars_i[0], 22);
    maj   = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
    t2    = big_a + maj;

    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;

    // W[t+16] from the rolling window
    s0 = sha_pkg::rotr(taps_i.w1, 7) ^ sha_pkg::rotr(taps_i.w1, 18) ^ (taps_i.w1 >> 3);
    s1 = sha_pkg::rotr(taps_i.w14, 17) ^ sha_pkg::rotr(taps_i.w14, 19)
       ^ (taps_i.w14 >> 10);
    w_next_o = taps_i.w0 + s0 + taps_i.w9 + s1;
  end

endmodule

/* rtl/sha256_message_hasher.sv */
// SHA-256 message hasher top level: byte loader, padding sequencer and round loop.
`timescale 1ns / 1ps
// SHA-256 (FIPS 180-4) over a byte stream given as left-aligned big-endian words.
// Each input transaction carries 0..4 bytes (counts 5..7 act as 4); tlast ends the
// message, after which the block pads, finishes and presents the 256-bit digest as
// one output transaction, then starts the next message from the initial hash.
// Flow: an input transaction is taken in S_IDLE, then its bytes are loaded one per
// cycle while no compression runs, and the item closes in S_DATA before the next
// transaction is taken. Every 64th byte triggers a compression (64 rounds through
// the single round unit, then the hash update), which holds the loading. The last
// item further loads the pad byte, zeros and eight length bytes one per cycle,
// again held by one or two compressions, before the digest is presented. The
// byte-serial loader and the one-round-per-cycle unit set the pace. The digest sits
// in an output register, so a new message may start while it waits; a second digest
// waits for the first to be taken.
module sha256_message_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [39:0]  s_axis_tdata_i,  // [31:0] data_word, [34:32] byte_count, rest 0
  input  logic         s_axis_tlast_i,  // last_word
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [255:0] m_axis_tdata_o   // digest_w0 [31:0] up to digest_w7 [255:224]
);

  `include "sha256_message_hasher_assert.svh"

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DATA   = 3'd1;
  localparam logic [2:0] S_PAD    = 3'd2;
  localparam logic [2:0] S_ZERO   = 3'd3;
  localparam logic [2:0] S_LEN    = 3'd4;
  localparam logic [2:0] S_ROUND  = 3'd5;
  localparam logic [2:0] S_UPDATE = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]   state_q, state_d, ret_q, ret_d;
  logic [5:0]   blk_cnt_q, blk_cnt_d;    // bytes in the current block
  logic [5:0]   rnd_q, rnd_d;
  logic [2:0]   rem_q, rem_d;            // bytes of the item still to load
  logic [2:0]   len_idx_q, len_idx_d;
  logic         last_q, last_d;
  logic [31:0]  word_q, word_d;
  logic [63:0]  len_q, len_d;
  sha_pkg::hash_t hash_q, hash_d, vars_q, vars_d, vars_next;
  logic [15:0][31:0] sched_q, sched_d;   // index 0 holds the oldest word
  logic         out_valid_q, out_valid_d;
  logic [255:0] out_data_q, out_data_d;

  logic         in_fire, push_en, out_load;
  logic [7:0]   push_byte;
  logic [2:0]   cnt_clamped;
  logic [63:0]  len_shift;
  logic [31:0]  w_next;
  sha_pkg::sched_taps_t taps;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign cnt_clamped     = s_axis_tdata_i[34] ? 3'd4 : s_axis_tdata_i[34:32];
  assign len_shift       = len_q >> {~len_idx_q, 3'b000};
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  assign taps.w0  = sched_q[0];
  assign taps.w1  = sched_q[1];
  assign taps.w9  = sched_q[9];
  assign taps.w14 = sched_q[14];

  sha_round u_round (
    .vars_i   (vars_q),
    .taps_i   (taps),
    .k_i      (sha_pkg::round_k(rnd_q)),
    .vars_o   (vars_next),
    .w_next_o (w_next)
  );

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    blk_cnt_d   = blk_cnt_q;
    rnd_d       = rnd_q;
    rem_d       = rem_q;
    len_idx_d   = len_idx_q;
    last_d      = last_q;
    word_d      = word_q;
    len_d       = len_q;
    hash_d      = hash_q;
    vars_d      = vars_q;
    sched_d     = sched_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    push_en     = 1'b0;
    push_byte   = 8'h00;
    out_load    = 1'b0;

    // Drop the digest once the downstream side takes it
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          word_d  = s_axis_tdata_i[31:0];
          rem_d   = cnt_clamped;
          last_d  = s_axis_tlast_i;
          len_d   = len_q + {58'd0, cnt_clamped, 3'b000};
          state_d = S_DATA;
        end
      end
      S_DATA: begin
        if (rem_q != 3'd0) begin
          push_en   = 1'b1;
          push_byte = word_q[31:24];
          word_d    = {word_q[23:0], 8'h00};
          rem_d     = rem_q - 3'd1;
          ret_d     = S_DATA;
        end else begin
          state_d = last_q ? S_PAD : S_IDLE;
        end
      end
      S_PAD: begin
        push_en   = 1'b1;
        push_byte = sha_pkg::PadMark;
        ret_d     = S_ZERO;
        state_d   = S_ZERO;
      end
      S_ZERO: begin
        if (blk_cnt_q == sha_pkg::LenFieldPos) begin
          len_idx_d = 3'd0;
          state_d   = S_LEN;
        end else begin
          push_en = 1'b1;
          ret_d   = S_ZERO;
        end
      end
      S_LEN: begin
        push_en   = 1'b1;
        push_byte = len_shift[7:0];
        len_idx_d = len_idx_q + 3'd1;
        ret_d     = (len_idx_q == 3'd7) ? S_FIN : S_LEN;
      end
      S_ROUND: begin
        vars_d = vars_next;
        for (int i = 0; i < 15; i++) begin
          sched_d[i] = sched_q[i + 1];
        end
        sched_d[15] = w_next;
        rnd_d       = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + vars_q[i];
        end
        state_d = ret_q;
      end
      S_FIN: begin
        // Hold the finished digest until the output register is free
        if (!out_valid_q || m_axis_tready_i) begin
          out_load    = 1'b1;
          out_data_d  = hash_q;
          out_valid_d = 1'b1;
          hash_d      = sha_pkg::HashInit;
          len_d       = 64'd0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Shift one byte into the block buffer; a full block starts compression
    if (push_en) begin
      for (int i = 0; i < 15; i++) begin
        sched_d[i] = {sched_q[i][23:0], sched_q[i + 1][31:24]};
      end
      sched_d[15] = {sched_q[15][23:0], push_byte};
      blk_cnt_d   = blk_cnt_q + 6'd1;
      if (blk_cnt_q == 6'd63) begin
        vars_d  = hash_q;
        rnd_d   = 6'd0;
        state_d = S_ROUND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      blk_cnt_q   <= 6'd0;
      rnd_q       <= 6'd0;
      rem_q       <= 3'd0;
      len_idx_q   <= 3'd0;
      last_q      <= 1'b0;
      len_q       <= 64'd0;
      hash_q      <= sha_pkg::HashInit;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      blk_cnt_q   <= blk_cnt_d;
      rnd_q       <= rnd_d;
      rem_q       <= rem_d;
      len_idx_q   <= len_idx_d;
      last_q      <= last_d;
      len_q       <= len_d;
      hash_q      <= hash_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    vars_q     <= vars_d;
    sched_q    <= sched_d;
    out_data_q <= out_data_d;
  end

  `SHA_ASSERT(a_round_cnt_idle, (state_q != S_ROUND) |-> (rnd_q == 6'd0), "round count off")
  `SHA_ASSERT(a_block_empty_in_round, (state_q == S_ROUND) |-> (blk_cnt_q == 6'd0),
              "block buffer not empty during compression")
  `SHA_ASSERT(a_digest_from_fin, $rose(out_valid_q) |-> ($past(state_q) == S_FIN),
              "digest loaded outside finish")
  `SHA_ASSERT(a_restart_hash, out_load |=> (hash_q == sha_pkg::HashInit && len_q == 64'd0),
              "hash not restarted after digest")
  `SHA_ASSERT_NEVER(a_no_accept_busy, s_axis_tready_o && (state_q == S_ROUND),
                    "input ready during compression")

endmodule
